// ===== rtl/fsfa_pkg.sv =====
// Shared types, constants and the control program of the four-stream frame aligner.
`default_nettype none

package fsfa_pkg;

    localparam int NUM_Q       = 4;
    localparam int Q_W         = 2;
    localparam int QUEUE_DEPTH = 8;
    localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;
    localparam int NUM_ENTRIES = NUM_Q * QUEUE_DEPTH;
    localparam int ADDR_W      = $clog2(NUM_ENTRIES);
    localparam int STAMP_W     = 63;
    localparam int TAG_W       = 32;
    localparam int TOL_W       = 32;
    localparam int KIND_W      = 2;
    localparam int PC_W        = 5;

    localparam logic [TOL_W-1:0] PAIR_TOL_RST   = 32'd1000000;
    localparam logic [TOL_W-1:0] STEREO_TOL_RST = 32'd3000000;

    // Configuration register indexes.
    localparam logic REG_PAIR_TOL   = 1'b0;
    localparam logic REG_STEREO_TOL = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_DROP     = 2'd0,
        KIND_MATCH    = 2'd1,
        KIND_OVERFLOW = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_PUSH,
        OP_READ,
        OP_CMP,
        OP_BRANCH,
        OP_POP
    } op_t;

    // Which queue a read or a pop works on.
    typedef enum logic [2:0] {
        QS_0,
        QS_1,
        QS_2,
        QS_3,
        QS_OLD01,
        QS_OLD23,
        QS_DEV_CH0,
        QS_DEV_CH1
    } qsel_t;

    // Head pairs compared by the gap unit; also the branch conditions.
    typedef enum logic [1:0] {
        PR_01,
        PR_23,
        PR_02
    } pair_t;

    typedef struct packed {
        op_t             op;
        qsel_t           qsel;
        pair_t           pair;
        kind_t           kind;
        logic            end_iter;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic gt;
        logic a_older;
    } cmp_res_t;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [TAG_W-1:0]   tag;
    } entry_t;

    localparam logic [PC_W-1:0] PC_WAIT  = 5'd0;
    localparam logic [PC_W-1:0] PC_READ  = 5'd2;
    localparam logic [PC_W-1:0] PC_DROP01 = 5'd16;
    localparam logic [PC_W-1:0] PC_DROPDEV = 5'd17;
    localparam logic [PC_W-1:0] PC_DROP23 = 5'd19;

    // Control program. Steps 2..8 fetch the four heads and evaluate the three
    // gaps, steps 9..11 pick the rule, and the pops close each iteration.
    function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = '{op: OP_WAIT, qsel: QS_0, pair: PR_01, kind: KIND_DROP,
              end_iter: 1'b0, target: PC_WAIT};
        case (pc)
            5'd0:  w.op = OP_WAIT;
            5'd1:  w.op = OP_PUSH;
            5'd2:  begin w.op = OP_READ; w.qsel = QS_0; end
            5'd3:  begin w.op = OP_READ; w.qsel = QS_1; end
            5'd4:  begin w.op = OP_READ; w.qsel = QS_2; end
            5'd5:  begin w.op = OP_READ; w.qsel = QS_3; end
            5'd6:  begin w.op = OP_CMP; w.pair = PR_01; end
            5'd7:  begin w.op = OP_CMP; w.pair = PR_23; end
            5'd8:  begin w.op = OP_CMP; w.pair = PR_02; end
            5'd9:  begin w.op = OP_BRANCH; w.pair = PR_01; w.target = PC_DROP01; end
            5'd10: begin w.op = OP_BRANCH; w.pair = PR_23; w.target = PC_DROP23; end
            5'd11: begin w.op = OP_BRANCH; w.pair = PR_02; w.target = PC_DROPDEV; end
            5'd12: begin w.op = OP_POP; w.qsel = QS_0; w.kind = KIND_MATCH; end
            5'd13: begin w.op = OP_POP; w.qsel = QS_1; w.kind = KIND_MATCH; end
            5'd14: begin w.op = OP_POP; w.qsel = QS_2; w.kind = KIND_MATCH; end
            5'd15:
            begin
                w.op = OP_POP; w.qsel = QS_3; w.kind = KIND_MATCH; w.end_iter = 1'b1;
            end
            5'd16: begin w.op = OP_POP; w.qsel = QS_OLD01; w.end_iter = 1'b1; end
            5'd17: begin w.op = OP_POP; w.qsel = QS_DEV_CH0; end
            5'd18: begin w.op = OP_POP; w.qsel = QS_DEV_CH1; w.end_iter = 1'b1; end
            5'd19: begin w.op = OP_POP; w.qsel = QS_OLD23; w.end_iter = 1'b1; end
            default: w.op = OP_WAIT;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fsfa_gap_cmp.sv =====
// Absolute timestamp gap against a tolerance, with the older of the two stamps.
`default_nettype none

module fsfa_gap_cmp
    import fsfa_pkg::*;
(
    input  wire logic [STAMP_W-1:0] a,
    input  wire logic [STAMP_W-1:0] b,
    input  wire logic [TOL_W-1:0]   tol,
    output cmp_res_t                res
);

    logic [STAMP_W:0]   a_minus_b;
    logic [STAMP_W:0]   b_minus_a;
    logic               a_lt_b;
    logic [STAMP_W-1:0] gap;

    assign a_minus_b = {1'b0, a} - {1'b0, b};
    assign b_minus_a = {1'b0, b} - {1'b0, a};
    // The borrow out of a - b says a is the smaller stamp.
    assign a_lt_b    = a_minus_b[STAMP_W];
    assign gap       = a_lt_b ? b_minus_a[STAMP_W-1:0] : a_minus_b[STAMP_W-1:0];

    assign res.gt      = gap > STAMP_W'(tol);
    assign res.a_older = a_lt_b;

endmodule

`default_nettype wire

// ===== rtl/four_stream_frame_aligner.sv =====
// Top level of the four-stream frame aligner: queues, entry RAM and control sequencer.
`default_nettype none

// Four frame queues (device x channel) share one entry RAM, with one write and one
// read port, and are run by a small control program. An item from any queue other
// than device 0, channel 0 causes at most an overflow result. An item for device 0,
// channel 0 then runs matching iterations while all four queues hold a frame: each
// iteration reads the four heads one after another from the RAM and checks the
// three gaps through one shared comparator, then pops one, two or four heads at one
// result per cycle when the output is free. The input is stalled for the whole of
// an item's work. Results carry last on the final result of an item; an item that
// causes no result is silent.
module four_stream_frame_aligner
    import fsfa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [TOL_W-1:0]   cfg_data,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               device,
    input  wire logic               channel,
    input  wire logic [STAMP_W-1:0] stamp,
    input  wire logic [TAG_W-1:0]   frame_tag,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [KIND_W-1:0]       kind,
    output logic                    out_device,
    output logic                    out_channel,
    output logic [STAMP_W-1:0]      out_stamp,
    output logic [TAG_W-1:0]        out_tag,
    output logic                    last
);

    ctrl_word_t         cw;
    logic [PC_W-1:0]    pc_reg, pc_next;

    logic [CNT_W-1:0]   cnt_reg [NUM_Q];
    logic [CNT_W-1:0]   cnt_next [NUM_Q];
    logic [QIDX_W-1:0]  head_reg [NUM_Q];
    logic [QIDX_W-1:0]  head_next [NUM_Q];
    logic [STAMP_W-1:0] hstamp_reg [NUM_Q];
    logic [STAMP_W-1:0] hstamp_next [NUM_Q];
    logic [TAG_W-1:0]   htag_reg [NUM_Q];
    logic [TAG_W-1:0]   htag_next [NUM_Q];

    cmp_res_t           res01_reg, res01_next;
    cmp_res_t           res23_reg, res23_next;
    cmp_res_t           res02_reg, res02_next;

    logic [Q_W-1:0]     in_q_reg, in_q_next;
    logic [STAMP_W-1:0] in_stamp_reg, in_stamp_next;
    logic [TAG_W-1:0]   in_tag_reg, in_tag_next;

    logic [TOL_W-1:0]   pair_tol_reg, pair_tol_next;
    logic [TOL_W-1:0]   stereo_tol_reg, stereo_tol_next;

    logic               out_valid_reg, out_valid_next;
    kind_t              out_kind_reg, out_kind_next;
    logic [Q_W-1:0]     out_q_reg, out_q_next;
    logic [STAMP_W-1:0] out_stamp_reg, out_stamp_next;
    logic [TAG_W-1:0]   out_tag_reg, out_tag_next;
    logic               out_last_reg, out_last_next;

    logic               cap_valid_reg, cap_valid_next;
    logic [Q_W-1:0]     cap_q_reg, cap_q_next;
    entry_t             rd_entry_reg;

    entry_t             entry_ram [NUM_ENTRIES];
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    entry_t             mem_wentry;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;

    logic [STAMP_W-1:0] cmp_a, cmp_b;
    logic [TOL_W-1:0]   cmp_tol;
    cmp_res_t           cmp_res;

    logic               out_free;
    logic               full;
    logic               go_match;
    logic [Q_W-1:0]     sel_q;
    logic               all_nz_after;
    logic               branch_taken;
    logic [SUM_W-1:0]   tail_sum;
    logic [QIDX_W-1:0]  tail_idx;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [Q_W-1:0] q,
                                                    input logic [QIDX_W-1:0] idx);
        return ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(idx);
    endfunction

    assign cw = ucode(pc_reg);

    assign in_stall    = (cw.op != OP_WAIT);
    assign out_valid   = out_valid_reg;
    assign kind        = out_kind_reg;
    assign out_device  = out_q_reg[1];
    assign out_channel = out_q_reg[0];
    assign out_stamp   = out_stamp_reg;
    assign out_tag     = out_tag_reg;
    assign last        = out_last_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign full     = (cnt_reg[in_q_reg] == CNT_W'(QUEUE_DEPTH));
    // After the push, queue 0 is non-empty either way.
    assign go_match = (in_q_reg == 2'd0) && (cnt_reg[1] != '0) && (cnt_reg[2] != '0)
                      && (cnt_reg[3] != '0);

    assign tail_sum = SUM_W'(head_reg[in_q_reg]) + SUM_W'(cnt_reg[in_q_reg]);
    assign tail_idx = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                      ? QIDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : QIDX_W'(tail_sum);

    always_comb
    begin
        case (cw.qsel)
            QS_0:       sel_q = 2'd0;
            QS_1:       sel_q = 2'd1;
            QS_2:       sel_q = 2'd2;
            QS_3:       sel_q = 2'd3;
            QS_OLD01:   sel_q = res01_reg.a_older ? 2'd0 : 2'd1;
            QS_OLD23:   sel_q = res23_reg.a_older ? 2'd2 : 2'd3;
            QS_DEV_CH0: sel_q = res02_reg.a_older ? 2'd0 : 2'd2;
            QS_DEV_CH1: sel_q = res02_reg.a_older ? 2'd1 : 2'd3;
            default:    sel_q = 2'd0;
        endcase
    end

    // Whether every queue still holds a frame once the selected head is popped.
    always_comb
    begin
        all_nz_after = 1'b1;
        for (int i = 0; i < NUM_Q; i++)
        begin
            if (Q_W'(i) == sel_q)
                all_nz_after = all_nz_after && (cnt_reg[i] != CNT_W'(1));
            else
                all_nz_after = all_nz_after && (cnt_reg[i] != '0);
        end
    end

    always_comb
    begin
        case (cw.pair)
            PR_01:
            begin
                cmp_a = hstamp_reg[0]; cmp_b = hstamp_reg[1]; cmp_tol = pair_tol_reg;
                branch_taken = res01_reg.gt;
            end
            PR_23:
            begin
                cmp_a = hstamp_reg[2]; cmp_b = hstamp_reg[3]; cmp_tol = pair_tol_reg;
                branch_taken = res23_reg.gt;
            end
            PR_02:
            begin
                cmp_a = hstamp_reg[0]; cmp_b = hstamp_reg[2]; cmp_tol = stereo_tol_reg;
                branch_taken = res02_reg.gt;
            end
            default:
            begin
                cmp_a = hstamp_reg[0]; cmp_b = hstamp_reg[1]; cmp_tol = pair_tol_reg;
                branch_taken = 1'b0;
            end
        endcase
    end

    fsfa_gap_cmp u_gap_cmp
    (
        .a   (cmp_a),
        .b   (cmp_b),
        .tol (cmp_tol),
        .res (cmp_res)
    );

    always_comb
    begin
        pc_next         = pc_reg;
        cnt_next        = cnt_reg;
        head_next       = head_reg;
        hstamp_next     = hstamp_reg;
        htag_next       = htag_reg;
        res01_next      = res01_reg;
        res23_next      = res23_reg;
        res02_next      = res02_reg;
        in_q_next       = in_q_reg;
        in_stamp_next   = in_stamp_reg;
        in_tag_next     = in_tag_reg;
        pair_tol_next   = pair_tol_reg;
        stereo_tol_next = stereo_tol_reg;
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_q_next      = out_q_reg;
        out_stamp_next  = out_stamp_reg;
        out_tag_next    = out_tag_reg;
        out_last_next   = out_last_reg;
        cap_valid_next  = 1'b0;
        cap_q_next      = cap_q_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wentry      = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        // Read data lands in the cycle after the read step.
        if (cap_valid_reg)
        begin
            hstamp_next[cap_q_reg] = rd_entry_reg.stamp;
            htag_next[cap_q_reg]   = rd_entry_reg.tag;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                REG_PAIR_TOL:   pair_tol_next   = cfg_data;
                REG_STEREO_TOL: stereo_tol_next = cfg_data;
                default:        pair_tol_next   = pair_tol_reg;
            endcase
        end

        case (cw.op)
            OP_WAIT:
            begin
                if (in_valid)
                begin
                    in_q_next     = {device, channel};
                    in_stamp_next = stamp;
                    in_tag_next   = frame_tag;
                    pc_next       = pc_reg + 1'b1;
                end
            end
            OP_PUSH:
            begin
                if (full)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_OVERFLOW;
                        out_q_next     = in_q_reg;
                        out_stamp_next = in_stamp_reg;
                        out_tag_next   = in_tag_reg;
                        out_last_next  = !go_match;
                        pc_next        = go_match ? PC_READ : PC_WAIT;
                    end
                end
                else
                begin
                    mem_we             = 1'b1;
                    mem_waddr          = slot_addr(in_q_reg, tail_idx);
                    mem_wentry.stamp   = in_stamp_reg;
                    mem_wentry.tag     = in_tag_reg;
                    cnt_next[in_q_reg] = cnt_reg[in_q_reg] + 1'b1;
                    pc_next            = go_match ? PC_READ : PC_WAIT;
                end
            end
            OP_READ:
            begin
                mem_re         = 1'b1;
                mem_raddr      = slot_addr(sel_q, head_reg[sel_q]);
                cap_valid_next = 1'b1;
                cap_q_next     = sel_q;
                pc_next        = pc_reg + 1'b1;
            end
            OP_CMP:
            begin
                case (cw.pair)
                    PR_01:   res01_next = cmp_res;
                    PR_23:   res23_next = cmp_res;
                    PR_02:   res02_next = cmp_res;
                    default: res01_next = res01_reg;
                endcase
                pc_next = pc_reg + 1'b1;
            end
            OP_BRANCH:
            begin
                pc_next = branch_taken ? cw.target : pc_reg + 1'b1;
            end
            OP_POP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = cw.kind;
                    out_q_next      = sel_q;
                    out_stamp_next  = hstamp_reg[sel_q];
                    out_tag_next    = htag_reg[sel_q];
                    out_last_next   = cw.end_iter && !all_nz_after;
                    cnt_next[sel_q] = cnt_reg[sel_q] - 1'b1;
                    head_next[sel_q] = (head_reg[sel_q] == QIDX_W'(QUEUE_DEPTH - 1))
                                       ? '0 : head_reg[sel_q] + 1'b1;
                    if (cw.end_iter)
                        pc_next = all_nz_after ? PC_READ : PC_WAIT;
                    else
                        pc_next = pc_reg + 1'b1;
                end
            end
            default:
            begin
                pc_next = PC_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= PC_WAIT;
            pair_tol_reg   <= PAIR_TOL_RST;
            stereo_tol_reg <= STEREO_TOL_RST;
            out_valid_reg  <= 1'b0;
            cap_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_Q; i++)
            begin
                cnt_reg[i]  <= '0;
                head_reg[i] <= '0;
            end
        end
        else
        begin
            pc_reg         <= pc_next;
            pair_tol_reg   <= pair_tol_next;
            stereo_tol_reg <= stereo_tol_next;
            out_valid_reg  <= out_valid_next;
            cap_valid_reg  <= cap_valid_next;
            cnt_reg        <= cnt_next;
            head_reg       <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hstamp_reg    <= hstamp_next;
        htag_reg      <= htag_next;
        res01_reg     <= res01_next;
        res23_reg     <= res23_next;
        res02_reg     <= res02_next;
        in_q_reg      <= in_q_next;
        in_stamp_reg  <= in_stamp_next;
        in_tag_reg    <= in_tag_next;
        out_kind_reg  <= out_kind_next;
        out_q_reg     <= out_q_next;
        out_stamp_reg <= out_stamp_next;
        out_tag_reg   <= out_tag_next;
        out_last_reg  <= out_last_next;
        cap_q_reg     <= cap_q_next;
    end

    // Entry RAM: one write port, one read port with registered data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            entry_ram[mem_waddr] <= mem_wentry;
        if (mem_re)
            rd_entry_reg <= entry_ram[mem_raddr];
    end

endmodule

`default_nettype wire
